@@ src/sidf_pkg.sv @@
package sidf_pkg;

   localparam int NUM_CHANNELS_DEF = 2;
   localparam int FRAME_LEN        = 39;
   localparam int SUM_POS          = 38;
   localparam int FILL_W           = 6;
   localparam int BYTE_W           = 8;
   localparam int COUNT_W          = 32;

   localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hAA;
   localparam logic [BYTE_W-1:0] ID_A      = 8'h01;
   localparam logic [BYTE_W-1:0] ID_B      = 8'h02;

   typedef struct packed {
      logic              channel;
      logic [BYTE_W-1:0] in_byte;
      logic              chunk_last;
   } req_type;

   typedef struct packed {
      logic               channel_out;
      logic [BYTE_W-1:0]  out_byte;
      logic               frame_last;
      logic               status;
      logic [COUNT_W-1:0] good_total;
      logic [COUNT_W-1:0] bad_total;
   } rsp_type;

endpackage

@@ src/sync_id_frame_deframer.sv @@
// Bytes are accepted one per cycle while frames are being assembled, but a closing
// byte waits while the output is stalled. A checksum failure gives its status
// transaction in the cycle after the closing byte. A good frame streams its 39 bytes
// from the frame store, each read into the RAM output register and then into the
// result register before the next read; input waits until its last byte is loaded.
// Reset clears fill indexes, running sums and counters; the frame store is not cleared.
module sync_id_frame_deframer #(
   parameter int NUM_CHANNELS = sidf_pkg::NUM_CHANNELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sidf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sidf_pkg::rsp_type rsp_data
);

   localparam int DEPTH = NUM_CHANNELS * sidf_pkg::FRAME_LEN;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int FW    = sidf_pkg::FILL_W;
   localparam int BW    = sidf_pkg::BYTE_W;
   localparam int CW    = sidf_pkg::COUNT_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic [FW-1:0] fill_ff [NUM_CHANNELS];
   logic [BW-1:0] sum_ff  [NUM_CHANNELS];
   logic [CW-1:0] good_ff [NUM_CHANNELS];
   logic [CW-1:0] bad_ff  [NUM_CHANNELS];

   logic          state_ff, state_in;
   logic [CH_W-1:0] emit_ch_ff, emit_ch_in;
   logic [FW-1:0] emit_idx_ff, emit_idx_in;
   logic          rd_pend_ff, rd_pend_in;
   logic          rd_last_ff, rd_last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   sidf_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic          rsp_load;

   logic [CH_W-1:0] ch_idx;
   logic          ch_ok;
   logic [BW-1:0] in_b;
   logic [FW-1:0] pos;
   logic [BW-1:0] sum_cur;
   logic [FW-1:0] fill_in;
   logic [BW-1:0] sum_in;
   logic [FW-1:0] wr_pos;
   logic          store_en;
   logic          good_hit;
   logic          bad_hit;
   logic          accept;
   logic          upd;
   logic          out_free;
   logic          issue;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [BW-1:0] rd_data;

   assign ch_idx  = CH_W'(req_data.channel);
   assign ch_ok   = (32'(req_data.channel) < 32'(NUM_CHANNELS));
   assign in_b    = req_data.in_byte;
   assign pos     = ch_ok ? fill_ff[ch_idx] : '0;
   assign sum_cur = ch_ok ? sum_ff[ch_idx] : '0;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) ||
                      (!out_free && ch_ok && (pos == FW'(sidf_pkg::SUM_POS)));
   assign accept    = req_valid && !req_stall;
   assign upd       = accept && ch_ok;
   assign issue     = (state_ff == ST_EMIT) && !rd_pend_ff && out_free;

   always_comb begin
      fill_in  = pos;
      sum_in   = sum_cur;
      wr_pos   = pos;
      store_en = 1'b0;
      good_hit = 1'b0;
      bad_hit  = 1'b0;
      if (pos == '0) begin
         if (in_b == sidf_pkg::SYNC_BYTE) begin
            store_en = 1'b1;
            fill_in  = FW'(1);
            sum_in   = in_b;
         end
      end else if (pos == FW'(1)) begin
         if (in_b == sidf_pkg::ID_A || in_b == sidf_pkg::ID_B) begin
            store_en = 1'b1;
            fill_in  = FW'(2);
            sum_in   = sum_cur + in_b;
         end else if (in_b == sidf_pkg::SYNC_BYTE) begin
            store_en = 1'b1;
            wr_pos   = '0;
            fill_in  = FW'(1);
            sum_in   = in_b;
         end else begin
            fill_in = '0;
         end
      end else begin
         store_en = 1'b1;
         if (pos < FW'(sidf_pkg::SUM_POS)) begin
            fill_in = pos + FW'(1);
            sum_in  = sum_cur + in_b;
         end else begin
            fill_in  = '0;
            good_hit = (sum_cur == in_b);
            bad_hit  = (sum_cur != in_b);
         end
      end
   end

   assign wr_addr = AW'(32'(ch_idx) * sidf_pkg::FRAME_LEN) + AW'(wr_pos);
   assign rd_addr = AW'(32'(emit_ch_ff) * sidf_pkg::FRAME_LEN) + AW'(emit_idx_ff);

   sidf_ram #(
      .WIDTH(BW),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (upd && store_en),
      .wr_addr(wr_addr),
      .wr_data(in_b),
      .rd_en  (issue),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      emit_ch_in   = emit_ch_ff;
      emit_idx_in  = emit_idx_ff;
      rd_pend_in   = 1'b0;
      rd_last_in   = rd_last_ff;
      rsp_load     = 1'b0;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (upd && good_hit) begin
               state_in    = ST_EMIT;
               emit_ch_in  = ch_idx;
               emit_idx_in = '0;
            end
            if (upd && bad_hit) begin
               rsp_load                = 1'b1;
               rsp_data_in.channel_out = req_data.channel;
               rsp_data_in.out_byte    = '0;
               rsp_data_in.frame_last  = 1'b1;
               rsp_data_in.status      = 1'b1;
               rsp_data_in.good_total  = good_ff[ch_idx];
               rsp_data_in.bad_total   = bad_ff[ch_idx] + CW'(1);
            end
         end
         ST_EMIT: begin
            if (issue) begin
               rd_pend_in  = 1'b1;
               rd_last_in  = (emit_idx_ff == FW'(sidf_pkg::SUM_POS));
               emit_idx_in = emit_idx_ff + FW'(1);
            end
            if (rd_pend_ff) begin
               rsp_load                = 1'b1;
               rsp_data_in.channel_out = 1'(emit_ch_ff);
               rsp_data_in.out_byte    = rd_data;
               rsp_data_in.frame_last  = rd_last_ff;
               rsp_data_in.status      = 1'b0;
               rsp_data_in.good_total  = good_ff[emit_ch_ff];
               rsp_data_in.bad_total   = bad_ff[emit_ch_ff];
               if (rd_last_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            fill_ff[i] <= '0;
            sum_ff[i]  <= '0;
            good_ff[i] <= '0;
            bad_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (upd) begin
            fill_ff[ch_idx] <= fill_in;
            sum_ff[ch_idx]  <= sum_in;
            if (good_hit) begin
               good_ff[ch_idx] <= good_ff[ch_idx] + CW'(1);
            end
            if (bad_hit) begin
               bad_ff[ch_idx] <= bad_ff[ch_idx] + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      emit_ch_ff  <= emit_ch_in;
      emit_idx_ff <= emit_idx_in;
      rd_last_ff  <= rd_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ src/sidf_ram.sv @@
module sidf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 78,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

   localparam logic STATUS_GOOD = 1'b0;
   localparam logic STATUS_BAD  = 1'b1;
   localparam int   ITEMS       = 170;
   localparam int   CALM_AFTER  = 140;
   localparam int   HOLD_CYCLES = 300;
   localparam int   IDLE_LIMIT  = 3000;
   localparam int   DRAIN_WAIT  = 200;

   class frame_scoreboard;
      sidf_pkg::rsp_type            pending[$];
      logic [sidf_pkg::BYTE_W-1:0]  store [2][sidf_pkg::FRAME_LEN];
      int unsigned                  fill [2];
      logic [sidf_pkg::COUNT_W-1:0] good [2];
      logic [sidf_pkg::COUNT_W-1:0] bad [2];
      int                           errors;
      int                           checked;
      int                           good_frames;
      int                           bad_frames;

      function new();
         for (int c = 0; c < 2; c++) begin
            fill[c] = 0;
            good[c] = '0;
            bad[c]  = '0;
         end
         errors      = 0;
         checked     = 0;
         good_frames = 0;
         bad_frames  = 0;
      endfunction

      function void note_byte(sidf_pkg::req_type t);
         int unsigned                 ch;
         int unsigned                 pos;
         int                          i;
         logic [sidf_pkg::BYTE_W-1:0] b;
         logic [sidf_pkg::BYTE_W-1:0] sum;
         sidf_pkg::rsp_type           r;
         ch  = 32'(t.channel);
         b   = t.in_byte;
         pos = fill[ch];
         if (pos == 0) begin
            if (b == sidf_pkg::SYNC_BYTE) begin
               store[ch][0] = b;
               fill[ch] = 1;
            end
         end else if (pos == 1) begin
            if (b == sidf_pkg::ID_A || b == sidf_pkg::ID_B) begin
               store[ch][1] = b;
               fill[ch] = 2;
            end else if (b == sidf_pkg::SYNC_BYTE) begin
               store[ch][0] = b;
               fill[ch] = 1;
            end else begin
               fill[ch] = 0;
            end
         end else begin
            store[ch][pos] = b;
            if (pos + 1 < sidf_pkg::FRAME_LEN) begin
               fill[ch] = pos + 1;
            end else begin
               fill[ch] = 0;
               sum = '0;
               for (i = 0; i < sidf_pkg::SUM_POS; i++) sum = sum + store[ch][i];
               r.channel_out = t.channel;
               if (sum != store[ch][sidf_pkg::SUM_POS]) begin
                  bad[ch] = bad[ch] + 1;
                  bad_frames++;
                  r.out_byte   = '0;
                  r.frame_last = 1'b1;
                  r.status     = STATUS_BAD;
                  r.good_total = good[ch];
                  r.bad_total  = bad[ch];
                  pending.push_back(r);
               end else begin
                  good[ch] = good[ch] + 1;
                  good_frames++;
                  for (i = 0; i < sidf_pkg::FRAME_LEN; i++) begin
                     r.out_byte   = store[ch][i];
                     r.frame_last = (i == sidf_pkg::FRAME_LEN - 1);
                     r.status     = STATUS_GOOD;
                     r.good_total = good[ch];
                     r.bad_total  = bad[ch];
                     pending.push_back(r);
                  end
               end
            end
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(sidf_pkg::rsp_type got);
         sidf_pkg::rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result transaction, expected none, actual %h",
                     $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         compare_field("channel_out", 32'(want.channel_out), 32'(got.channel_out));
         compare_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
         compare_field("frame_last", 32'(want.frame_last), 32'(got.frame_last));
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("good_total", want.good_total, got.good_total);
         compare_field("bad_total", want.bad_total, got.bad_total);
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   sidf_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   sidf_pkg::rsp_type rsp_data;

   frame_scoreboard sb = new();
   int   sent = 0;
   bit   calm = 1'b0;
   bit   random_phase = 1'b0;
   bit   held = 1'b0;
   logic [sidf_pkg::BYTE_W-1:0] plan0[$];
   logic [sidf_pkg::BYTE_W-1:0] plan1[$];

   sync_id_frame_deframer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic send_byte(input logic ch, input logic [sidf_pkg::BYTE_W-1:0] b,
                            input logic cl);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= {ch, b, cl};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(req_data);
      sent++;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (!held && random_phase && rsp_valid && rsp_data.status == STATUS_GOOD) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 17);
            rsp_stall <= 1'b1;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [sidf_pkg::BYTE_W-1:0] fresh[$];
      logic [sidf_pkg::BYTE_W-1:0] sum;
      logic [sidf_pkg::BYTE_W-1:0] b;
      logic                        ch;
      int                          kind;
      int                          n;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      send_byte(1'b0, 8'h00, 1'b1);
      send_byte(1'b1, 8'hFF, 1'b0);
      send_byte(1'b0, sidf_pkg::SYNC_BYTE, 1'b0);
      send_byte(1'b0, 8'h55, 1'b1);
      send_byte(1'b1, sidf_pkg::SYNC_BYTE, 1'b1);
      send_byte(1'b1, sidf_pkg::SYNC_BYTE, 1'b0);
      send_byte(1'b1, sidf_pkg::ID_B, 1'b0);
      send_byte(1'b0, sidf_pkg::SYNC_BYTE, 1'b0);
      send_byte(1'b0, sidf_pkg::ID_A, 1'b1);
      send_byte(1'b0, 8'hFF, 1'b0);
      send_byte(1'b1, 8'h00, 1'b1);

      random_phase = 1'b1;
      while (sent < ITEMS) begin
         ch = 1'($urandom_range(0, 1));
         if ((ch ? plan1.size() : plan0.size()) == 0) begin
            fresh.delete();
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
               fresh.push_back(sidf_pkg::SYNC_BYTE);
               fresh.push_back($urandom_range(0, 1) ? sidf_pkg::ID_A : sidf_pkg::ID_B);
               for (n = 2; n < sidf_pkg::SUM_POS; n++) begin
                  b = 8'($urandom_range(0, 255));
                  fresh.push_back(b);
               end
               sum = '0;
               foreach (fresh[k]) sum = sum + fresh[k];
               if ($urandom_range(0, 9) < 3) sum = sum + 8'($urandom_range(1, 255));
               fresh.push_back(sum);
            end else if (kind < 85) begin
               fresh.push_back(sidf_pkg::SYNC_BYTE);
               b = 8'($urandom_range(0, 255));
               while (b == sidf_pkg::ID_A || b == sidf_pkg::ID_B) begin
                  b = 8'($urandom_range(0, 255));
               end
               fresh.push_back(b);
            end else begin
               b = 8'($urandom_range(0, 255));
               fresh.push_back(b);
            end
            if (ch) plan1 = fresh;
            else plan0 = fresh;
         end
         if ($urandom_range(0, 99) == 0) b = 8'($urandom_range(0, 255));
         else if (ch) b = plan1.pop_front();
         else b = plan0.pop_front();
         send_byte(ch, b, 1'($urandom_range(0, 1)));
         if (sent >= CALM_AFTER) calm = 1'b1;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Run covered %0d bytes on two channels, %0d good and %0d bad frames,",
               sent, sb.good_frames, sb.bad_frames);
      $display("and %0d result transactions checked, with one long output hold-off.",
               sb.checked);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
